>>> sv/tlpq_pkg.sv
// Package for the three-level priority queue: field widths, the stored job
// entry type, result status codes and the sequencer state type.
// No dependencies; used by sv/three_level_priority_queue.sv.
package tlpq_pkg;

    // Payload field widths.
    localparam int unsigned IdW   = 16;
    localparam int unsigned PrioW = 2;
    localparam int unsigned TimeW = 16;

    // Default number of jobs the queue can hold.
    localparam int unsigned DefaultCapacity = 16;

    // One stored job.
    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
        logic [TimeW-1:0] jtime;
    } entry_t;

    // Request codes on the action field.
    typedef enum logic {
        ACT_ADD    = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_REMOVED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_INS,
        S_POP_RD,
        S_POP,
        S_RESP
    } state_t;

endpackage

>>> sv/three_level_priority_queue.sv
// Three-level stable priority queue: top level with the job memory and its
// insertion and removal sequencer.
// Depends on tlpq_pkg (sv/tlpq_pkg.sv).

// Each input transaction either adds a job (placed behind every stored job of
// equal or higher priority) or removes the head job, and yields exactly one
// result transaction. Jobs sit in a circular buffer in a single memory with one
// registered read port and one write port. A remove reads the head entry in
// S_POP_RD and takes it from the read register in S_POP before the result is
// offered. An add walks backwards from the tail, reading each entry in S_RD,
// comparing its priority with the new job's in S_CMP and moving it up by one
// place if it is lower; the walk ends and S_INS writes the new job once an
// entry of equal or higher priority is met or the head entry has moved. An
// add to an empty queue goes straight to S_INS; an add to a full queue or a
// remove from an empty queue goes straight to the result. The block takes
// one transaction at a time: s_ready is low from acceptance until the result
// has been taken. A priority of zero is stored as 1. No clearing pass is
// needed after reset.
module three_level_priority_queue #(
    parameter int unsigned CAPACITY = tlpq_pkg::DefaultCapacity
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [tlpq_pkg::IdW-1:0]   s_job_id,
    input  logic [tlpq_pkg::PrioW-1:0] s_job_priority,
    input  logic [tlpq_pkg::TimeW-1:0] s_job_time,
    // Result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [tlpq_pkg::IdW-1:0]   m_out_id,
    output logic [tlpq_pkg::PrioW-1:0] m_out_priority,
    output logic [tlpq_pkg::TimeW-1:0] m_out_time
);

    localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CntW = $clog2(CAPACITY + 1);
    localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);
    localparam logic [IdxW:0]   CapSum = (IdxW + 1)'(CAPACITY);

    tlpq_pkg::state_t state_reg, state_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [IdxW-1:0]  head_reg, head_next;
    logic [IdxW-1:0]  walk_reg, walk_next;
    tlpq_pkg::entry_t job_reg, job_next;

    tlpq_pkg::status_t          status_reg, status_next;
    logic [tlpq_pkg::IdW-1:0]   out_id_reg, out_id_next;
    logic [tlpq_pkg::PrioW-1:0] out_prio_reg, out_prio_next;
    logic [tlpq_pkg::TimeW-1:0] out_time_reg, out_time_next;

    // Job memory and its ports.
    tlpq_pkg::entry_t mem [CAPACITY];
    tlpq_pkg::entry_t rd_data_reg;
    logic [IdxW-1:0]  rd_addr;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    tlpq_pkg::entry_t wr_data;

    logic             in_fire;
    logic             out_fire;
    logic             is_full;
    logic             is_empty;
    logic [IdxW-1:0]  walk_prev;
    logic [IdxW-1:0]  addr_walk;
    logic [IdxW-1:0]  addr_prev;
    logic [tlpq_pkg::PrioW-1:0] in_prio;

    // Logical position from the head to memory address, wrapping once.
    function automatic logic [IdxW-1:0] to_addr(input logic [IdxW-1:0] head,
                                                input logic [IdxW-1:0] pos);
        logic [IdxW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= CapSum) begin
            sum = sum - CapSum;
        end
        return sum[IdxW-1:0];
    endfunction

    // Handshakes and queue status.
    assign s_ready  = (state_reg == tlpq_pkg::S_IDLE);
    assign m_valid  = (state_reg == tlpq_pkg::S_RESP);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign is_full  = (count_reg >= CapCnt);
    assign is_empty = (count_reg == '0);

    // Priority zero saturates to the lowest level.
    assign in_prio   = (s_job_priority == '0) ? tlpq_pkg::PrioW'(1) : s_job_priority;
    assign walk_prev = walk_reg - IdxW'(1);
    assign addr_walk = to_addr(head_reg, walk_reg);
    assign addr_prev = to_addr(head_reg, walk_prev);

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tlpq_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (s_action == tlpq_pkg::ACT_ADD) begin
                        if (is_full) begin
                            state_next = tlpq_pkg::S_RESP;
                        end else if (is_empty) begin
                            state_next = tlpq_pkg::S_INS;
                        end else begin
                            state_next = tlpq_pkg::S_RD;
                        end
                    end else begin
                        state_next = is_empty ? tlpq_pkg::S_RESP : tlpq_pkg::S_POP_RD;
                    end
                end
            end
            tlpq_pkg::S_RD: begin
                state_next = tlpq_pkg::S_CMP;
            end
            tlpq_pkg::S_CMP: begin
                if ((rd_data_reg.prio < job_reg.prio) && (walk_reg != IdxW'(1))) begin
                    state_next = tlpq_pkg::S_RD;
                end else begin
                    state_next = tlpq_pkg::S_INS;
                end
            end
            tlpq_pkg::S_INS: begin
                state_next = tlpq_pkg::S_RESP;
            end
            tlpq_pkg::S_POP_RD: begin
                state_next = tlpq_pkg::S_POP;
            end
            tlpq_pkg::S_POP: begin
                state_next = tlpq_pkg::S_RESP;
            end
            tlpq_pkg::S_RESP: begin
                if (out_fire) begin
                    state_next = tlpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tlpq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls for each state.
    always_comb begin
        count_next    = count_reg;
        head_next     = head_reg;
        walk_next     = walk_reg;
        job_next      = job_reg;
        status_next   = status_reg;
        out_id_next   = out_id_reg;
        out_prio_next = out_prio_reg;
        out_time_next = out_time_reg;
        rd_addr       = addr_prev;
        wr_en         = 1'b0;
        wr_addr       = addr_walk;
        wr_data       = job_reg;
        unique case (state_reg)
            tlpq_pkg::S_IDLE: begin
                if (in_fire) begin
                    job_next.id    = s_job_id;
                    job_next.prio  = in_prio;
                    job_next.jtime = s_job_time;
                    walk_next      = count_reg[IdxW-1:0];
                    out_id_next    = '0;
                    out_prio_next  = '0;
                    out_time_next  = '0;
                    if (s_action == tlpq_pkg::ACT_ADD) begin
                        status_next = is_full ? tlpq_pkg::ST_FULL : tlpq_pkg::ST_ADDED;
                    end else begin
                        status_next = is_empty ? tlpq_pkg::ST_EMPTY : tlpq_pkg::ST_REMOVED;
                    end
                end
            end
            tlpq_pkg::S_RD: begin
                rd_addr = addr_prev;
            end
            tlpq_pkg::S_CMP: begin
                // A lower-priority job moves one place towards the tail.
                if (rd_data_reg.prio < job_reg.prio) begin
                    wr_en     = 1'b1;
                    wr_data   = rd_data_reg;
                    walk_next = walk_prev;
                end
            end
            tlpq_pkg::S_INS: begin
                wr_en      = 1'b1;
                wr_data    = job_reg;
                count_next = count_reg + CntW'(1);
            end
            tlpq_pkg::S_POP_RD: begin
                rd_addr = head_reg;
            end
            tlpq_pkg::S_POP: begin
                out_id_next   = rd_data_reg.id;
                out_prio_next = rd_data_reg.prio;
                out_time_next = rd_data_reg.jtime;
                head_next     = to_addr(head_reg, IdxW'(1));
                count_next    = count_reg - CntW'(1);
            end
            tlpq_pkg::S_RESP: begin
                rd_addr = addr_prev;
            end
            default: begin
                rd_addr = addr_prev;
            end
        endcase
    end

    // Job memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlpq_pkg::S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        walk_reg     <= walk_next;
        job_reg      <= job_next;
        status_reg   <= status_next;
        out_id_reg   <= out_id_next;
        out_prio_reg <= out_prio_next;
        out_time_reg <= out_time_next;
    end

    assign m_status       = status_reg;
    assign m_out_id       = out_id_reg;
    assign m_out_priority = out_prio_reg;
    assign m_out_time     = out_time_reg;

    // The fill level never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CapCnt)
        else $error("queue fill level above capacity");

    // The fill level changes only on an insertion or a pop.
    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == tlpq_pkg::S_INS || $past(state_reg) == tlpq_pkg::S_POP))
        else $error("fill level changed outside insert or pop");

    // A removed job always carries a non-zero priority.
    a_removed_prio: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == tlpq_pkg::ST_REMOVED) |-> (m_out_priority != '0))
        else $error("removed job with priority zero");

    // The walk never runs past the head of the queue.
    a_walk_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlpq_pkg::S_RD || state_reg == tlpq_pkg::S_CMP) |-> (walk_reg != '0))
        else $error("insertion walk beyond the head");

endmodule
